@@ rtl/damped_spring_force_defines.svh @@
// Assertion macros for the spring force block.
// All checks are sampled on the rising edge of i_clk.
`ifndef DAMPED_SPRING_FORCE_DEFINES_SVH
`define DAMPED_SPRING_FORCE_DEFINES_SVH

// Check that is ignored while reset is low.
`define DSF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("damped_spring_force: check failed");

// Check that also holds across reset.
`define DSF_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("damped_spring_force: reset check failed");

`endif

@@ rtl/dsf_pkg.sv @@
package dsf_pkg;

    // field and fixed point widths
    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int CFG_W  = 31;
    localparam int D_W    = WORD_W + 1;          // difference vector component
    localparam int SQ_W   = 2 * D_W;             // sum of squares
    localparam int LEN_W  = D_W + 1;             // floor sqrt of SQ_W bits
    localparam int Q_W    = FRAC_W + 1;          // unit vector magnitude, <= 1.0

    // pipeline depth: front end, root, divide, back end
    localparam int FRONT_STAGES = 3;
    localparam int BACK_STAGES  = 6;
    localparam int DSF_LAT      = FRONT_STAGES + LEN_W + Q_W + BACK_STAGES;

    // register map
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_REST = 2'd0;
    localparam t_cfg_idx CFG_KS   = 2'd1;
    localparam t_cfg_idx CFG_KD   = 2'd2;

    localparam logic [CFG_W-1:0] REST_RST = CFG_W'(65536);
    localparam logic [CFG_W-1:0] KS_RST   = CFG_W'(65536);
    localparam logic [CFG_W-1:0] KD_RST   = CFG_W'(0);

    typedef logic [2:0][D_W-1:0] t_vec;

    // data riding along the root pipeline
    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
        t_vec       mag;
        t_vec       vel;
    } t_sq_side;

    // data riding along the divide pipeline
    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        t_vec             vel;
        logic [LEN_W-1:0] len;
    } t_dv_side;

endpackage

@@ rtl/dsf_sqrt.sv @@
module dsf_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [dsf_pkg::SQ_W-1:0]   i_num,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_vld,
    output logic [dsf_pkg::LEN_W-1:0]  o_root,
    output logic [SIDE_W-1:0]          o_side
);
    import dsf_pkg::*;

    localparam int NUM_W = 2 * LEN_W;
    localparam int REM_W = LEN_W + 2;

    logic [NUM_W-1:0]  r_num  [LEN_W];
    logic [REM_W-1:0]  r_rem  [LEN_W];
    logic [LEN_W-1:0]  r_root [LEN_W];
    logic [SIDE_W-1:0] r_side [LEN_W];
    logic              r_vld  [LEN_W];

    // one root bit per stage, restoring digit recurrence
    for (genvar k = 0; k < LEN_W; k++) begin : g_stage
        logic [NUM_W-1:0]  in_num;
        logic [REM_W-1:0]  in_rem;
        logic [LEN_W-1:0]  in_root;
        logic [SIDE_W-1:0] in_side;
        logic              in_vld;
        logic [REM_W+1:0]  n_cur;
        logic [REM_W+1:0]  n_trial;

        if (k == 0) begin : g_first
            assign in_num  = {{(NUM_W-SQ_W){1'b0}}, i_num};
            assign in_rem  = '0;
            assign in_root = '0;
            assign in_side = i_side;
            assign in_vld  = i_vld;
        end else begin : g_next
            assign in_num  = r_num[k-1];
            assign in_rem  = r_rem[k-1];
            assign in_root = r_root[k-1];
            assign in_side = r_side[k-1];
            assign in_vld  = r_vld[k-1];
        end

        assign n_cur   = {in_rem, in_num[NUM_W-1 -: 2]};
        assign n_trial = {2'b00, in_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= in_vld;
            end
            r_num[k]  <= {in_num[NUM_W-3:0], 2'b00};
            r_side[k] <= in_side;
            if (n_cur >= n_trial) begin
                r_rem[k]  <= REM_W'(n_cur - n_trial);
                r_root[k] <= {in_root[LEN_W-2:0], 1'b1};
            end else begin
                r_rem[k]  <= REM_W'(n_cur);
                r_root[k] <= {in_root[LEN_W-2:0], 1'b0};
            end
        end
    end

    assign o_vld  = r_vld[LEN_W-1];
    assign o_root = r_root[LEN_W-1];
    assign o_side = r_side[LEN_W-1];

endmodule

@@ rtl/dsf_div.sv @@
module dsf_div #(
    parameter int SIDE_W = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [dsf_pkg::LEN_W-1:0]           i_den,
    input  dsf_pkg::t_vec                       i_mag,
    input  logic [SIDE_W-1:0]                   i_side,
    output logic                                o_vld,
    output logic [2:0][dsf_pkg::Q_W-1:0]        o_quo,
    output logic [SIDE_W-1:0]                   o_side
);
    import dsf_pkg::*;

    localparam int REM_W = LEN_W + Q_W;

    logic [2:0][REM_W-1:0] r_rem  [Q_W];
    logic [2:0][Q_W-1:0]   r_quo  [Q_W];
    logic [LEN_W-1:0]      r_den  [Q_W];
    logic [SIDE_W-1:0]     r_side [Q_W];
    logic                  r_vld  [Q_W];

    // one quotient bit per stage for all three lanes, divisor shared
    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int BIT = Q_W - 1 - j;
        logic [2:0][REM_W-1:0] in_rem;
        logic [2:0][Q_W-1:0]   in_quo;
        logic [LEN_W-1:0]      in_den;
        logic [SIDE_W-1:0]     in_side;
        logic                  in_vld;
        logic [REM_W-1:0]      n_sub;
        logic [2:0][REM_W-1:0] n_rem;
        logic [2:0][Q_W-1:0]   n_quo;

        if (j == 0) begin : g_first
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign in_rem[l] = REM_W'({i_mag[l], {FRAC_W{1'b0}}});
            end
            assign in_quo  = '0;
            assign in_den  = i_den;
            assign in_side = i_side;
            assign in_vld  = i_vld;
        end else begin : g_next
            assign in_rem  = r_rem[j-1];
            assign in_quo  = r_quo[j-1];
            assign in_den  = r_den[j-1];
            assign in_side = r_side[j-1];
            assign in_vld  = r_vld[j-1];
        end

        assign n_sub = REM_W'(in_den) << BIT;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_quo[l] = in_quo[l];
                if (in_rem[l] >= n_sub) begin
                    n_rem[l]      = in_rem[l] - n_sub;
                    n_quo[l][BIT] = 1'b1;
                end else begin
                    n_rem[l] = in_rem[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= in_vld;
            end
            r_rem[j]  <= n_rem;
            r_quo[j]  <= n_quo;
            r_den[j]  <= in_den;
            r_side[j] <= in_side;
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_quo  = r_quo[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

@@ rtl/damped_spring_force.sv @@
// Damped spring force between two particles, signed Q16.16 throughout.
//
// Input: pulse start with the twelve position and velocity fields; an item
// is taken at every clock edge where start is high and busy is low. busy is
// always low: the pipeline takes one particle pair per clock.
// Output: o_done is high for one cycle with the force on both particles and
// the zero_length and saturated flags. The receiver cannot stall.
// Pipeline: the depth is set by the square root (one bit per stage, 34 stages) and
// the unit vector divide (one quotient bit per stage, 17 stages), plus
// three front end and six back end stages for the multiplies and clipping.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 rest length, 1 stiffness, 2 damping); write only while no item is in
// flight. Unknown indexes are ignored.
// Reset: synchronous, active low; clears the pipeline valid bits and loads
// rest length 1.0, stiffness 1.0, damping 0.
`include "damped_spring_force_defines.svh"

module damped_spring_force (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  dsf_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [dsf_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_first_pos_x,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_first_pos_y,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_first_pos_z,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_second_pos_x,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_second_pos_y,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_second_pos_z,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_first_vel_x,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_first_vel_y,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_first_vel_z,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_second_vel_x,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_second_vel_y,
    input  logic signed [dsf_pkg::WORD_W-1:0] i_second_vel_z,
    output logic                              o_done,
    output logic signed [dsf_pkg::WORD_W-1:0] o_first_force_x,
    output logic signed [dsf_pkg::WORD_W-1:0] o_first_force_y,
    output logic signed [dsf_pkg::WORD_W-1:0] o_first_force_z,
    output logic signed [dsf_pkg::WORD_W-1:0] o_second_force_x,
    output logic signed [dsf_pkg::WORD_W-1:0] o_second_force_y,
    output logic signed [dsf_pkg::WORD_W-1:0] o_second_force_z,
    output logic                              o_zero_length,
    output logic                              o_saturated
);
    import dsf_pkg::*;

    localparam int PV_W  = D_W + 2;            // v_i * u_i, signed
    localparam int VU_W  = PV_W + 2;           // v . u, signed
    localparam int LMR_W = LEN_W + 2;          // L - r, signed
    localparam int S_W   = 53;                 // spring and damping terms, signed
    localparam int FM_W  = S_W + 1;            // force magnitude before clipping
    localparam logic [FM_W-1:0] POS_LIM = FM_W'((64'd1 << (WORD_W - 1)) - 64'd1);
    localparam logic [FM_W-1:0] NEG_LIM = FM_W'(64'd1 << (WORD_W - 1));
    localparam logic [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // configuration registers
    logic [CFG_W-1:0] r_rest, r_ks, r_kd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest <= REST_RST;
            r_ks   <= KS_RST;
            r_kd   <= KD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REST: r_rest <= i_cfg_data;
                CFG_KS:   r_ks   <= i_cfg_data;
                CFG_KD:   r_kd   <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic [2:0][WORD_W-1:0] w_p1, w_p2, w_v1, w_v2;
    assign w_p1 = {i_first_pos_z, i_first_pos_y, i_first_pos_x};
    assign w_p2 = {i_second_pos_z, i_second_pos_y, i_second_pos_x};
    assign w_v1 = {i_first_vel_z, i_first_vel_y, i_first_vel_x};
    assign w_v2 = {i_second_vel_z, i_second_vel_y, i_second_vel_x};

    // stage 1: difference vectors
    logic r_vld1;
    t_vec r_d1, r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= start && !busy;
        end
        for (int i = 0; i < 3; i++) begin
            r_d1[i] <= {w_p1[i][WORD_W-1], w_p1[i]} - {w_p2[i][WORD_W-1], w_p2[i]};
            r_v1[i] <= {w_v1[i][WORD_W-1], w_v1[i]} - {w_v2[i][WORD_W-1], w_v2[i]};
        end
    end

    // stage 2: magnitudes and squares
    logic                  r_vld2, r_zero2;
    logic [2:0]            r_neg2;
    t_vec                  r_mag2, r_v2;
    logic [2:0][SQ_W-1:0]  r_sq2;
    t_vec                  n_mag2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag2[i] = r_d1[i][D_W-1] ? D_W'(-r_d1[i]) : r_d1[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
        for (int i = 0; i < 3; i++) begin
            r_sq2[i]  <= SQ_W'(n_mag2[i]) * SQ_W'(n_mag2[i]);
            r_neg2[i] <= r_d1[i][D_W-1];
        end
        r_mag2  <= n_mag2;
        r_v2    <= r_v1;
        r_zero2 <= (r_d1 == '0);
    end

    // stage 3: sum of squares
    logic            r_vld3;
    logic [SQ_W-1:0] r_sum3;
    t_sq_side        r_side3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= r_vld2;
        end
        r_sum3       <= r_sq2[0] + r_sq2[1] + r_sq2[2];
        r_side3.zero <= r_zero2;
        r_side3.neg  <= r_neg2;
        r_side3.mag  <= r_mag2;
        r_side3.vel  <= r_v2;
    end

    // length, one bit per stage
    logic             w_sq_vld;
    logic [LEN_W-1:0] w_len;
    t_sq_side         w_sq_side;

    dsf_sqrt #(
        .SIDE_W ($bits(t_sq_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld3),
        .i_num   (r_sum3),
        .i_side  (r_side3),
        .o_vld   (w_sq_vld),
        .o_root  (w_len),
        .o_side  (w_sq_side)
    );

    // unit vector magnitudes |d_i| * 2^F / L
    t_dv_side            w_dv_in, w_dv_side;
    logic                w_dv_vld;
    logic [2:0][Q_W-1:0] w_quo;

    assign w_dv_in.zero = w_sq_side.zero;
    assign w_dv_in.neg  = w_sq_side.neg;
    assign w_dv_in.vel  = w_sq_side.vel;
    assign w_dv_in.len  = w_len;

    dsf_div #(
        .SIDE_W ($bits(t_dv_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_sq_vld),
        .i_den   (w_len),
        .i_mag   (w_sq_side.mag),
        .i_side  (w_dv_in),
        .o_vld   (w_dv_vld),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    // stage 4: v_i * u_i and L - r
    logic                    r_vld4, r_zero4;
    logic [2:0]              r_neg4;
    logic [2:0][Q_W-1:0]     r_q4;
    logic [2:0][PV_W-1:0]    r_pv4;
    logic [LMR_W-1:0]        r_lmr4;
    logic [2:0][PV_W-1:0]    n_pv4;
    logic [D_W-1:0]          n_vmag;
    logic [D_W+Q_W-1:0]      n_pprod;

    always_comb begin
        n_vmag  = '0;
        n_pprod = '0;
        for (int i = 0; i < 3; i++) begin
            n_vmag  = w_dv_side.vel[i][D_W-1] ? D_W'(-w_dv_side.vel[i]) : w_dv_side.vel[i];
            n_pprod = (D_W+Q_W)'(n_vmag) * (D_W+Q_W)'(w_quo[i]);
            if (w_dv_side.vel[i][D_W-1] != w_dv_side.neg[i]) begin
                n_pv4[i] = PV_W'(-{1'b0, n_pprod[D_W+Q_W-1:FRAC_W]});
            end else begin
                n_pv4[i] = PV_W'({1'b0, n_pprod[D_W+Q_W-1:FRAC_W]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else begin
            r_vld4 <= w_dv_vld;
        end
        r_pv4   <= n_pv4;
        r_lmr4  <= LMR_W'(w_dv_side.len) - LMR_W'(r_rest);
        r_q4    <= w_quo;
        r_neg4  <= w_dv_side.neg;
        r_zero4 <= w_dv_side.zero;
    end

    // stage 5: v . u and ks * (L - r)
    logic                r_vld5, r_zero5;
    logic [2:0]          r_neg5;
    logic [2:0][Q_W-1:0] r_q5;
    logic [VU_W-1:0]     r_vu5;
    logic [S_W-1:0]      r_kt5;
    logic [LMR_W-1:0]    n_lmag;
    logic [LMR_W+CFG_W-1:0] n_kprod;

    assign n_lmag  = r_lmr4[LMR_W-1] ? LMR_W'(-r_lmr4) : r_lmr4;
    assign n_kprod = (LMR_W+CFG_W)'(n_lmag) * (LMR_W+CFG_W)'(r_ks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else begin
            r_vld5 <= r_vld4;
        end
        r_vu5 <= VU_W'(signed'(r_pv4[0])) + VU_W'(signed'(r_pv4[1]))
               + VU_W'(signed'(r_pv4[2]));
        if (r_lmr4[LMR_W-1]) begin
            r_kt5 <= S_W'(-S_W'(n_kprod[LMR_W+CFG_W-1:FRAC_W]));
        end else begin
            r_kt5 <= S_W'(n_kprod[LMR_W+CFG_W-1:FRAC_W]);
        end
        r_q5    <= r_q4;
        r_neg5  <= r_neg4;
        r_zero5 <= r_zero4;
    end

    // stage 6: kd * (v . u)
    logic                r_vld6, r_zero6;
    logic [2:0]          r_neg6;
    logic [2:0][Q_W-1:0] r_q6;
    logic [S_W-1:0]      r_kt6, r_dt6;
    logic [VU_W-1:0]     n_vumag;
    logic [VU_W+CFG_W-1:0] n_dprod;

    assign n_vumag = r_vu5[VU_W-1] ? VU_W'(-r_vu5) : r_vu5;
    assign n_dprod = (VU_W+CFG_W)'(n_vumag) * (VU_W+CFG_W)'(r_kd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld6 <= 1'b0;
        end else begin
            r_vld6 <= r_vld5;
        end
        if (r_vu5[VU_W-1]) begin
            r_dt6 <= S_W'(-S_W'(n_dprod[VU_W+CFG_W-1:FRAC_W]));
        end else begin
            r_dt6 <= S_W'(n_dprod[VU_W+CFG_W-1:FRAC_W]);
        end
        r_kt6   <= r_kt5;
        r_q6    <= r_q5;
        r_neg6  <= r_neg5;
        r_zero6 <= r_zero5;
    end

    // stage 7: scalar force s
    logic                r_vld7, r_zero7;
    logic [2:0]          r_neg7;
    logic [2:0][Q_W-1:0] r_q7;
    logic [S_W-1:0]      r_s7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld7 <= 1'b0;
        end else begin
            r_vld7 <= r_vld6;
        end
        r_s7    <= r_kt6 + r_dt6;
        r_q7    <= r_q6;
        r_neg7  <= r_neg6;
        r_zero7 <= r_zero6;
    end

    // stage 8: s * u_i, magnitude and sign of the first force
    logic                 r_vld8, r_zero8;
    logic [2:0]           r_pos8;
    logic [2:0][FM_W-1:0] r_fm8;
    logic [S_W-1:0]       n_smag;
    logic [2:0][S_W+Q_W-1:0] n_fprod;

    assign n_smag = r_s7[S_W-1] ? S_W'(-r_s7) : r_s7;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_fprod[i] = (S_W+Q_W)'(n_smag) * (S_W+Q_W)'(r_q7[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld8 <= 1'b0;
        end else begin
            r_vld8 <= r_vld7;
        end
        for (int i = 0; i < 3; i++) begin
            r_fm8[i]  <= FM_W'(n_fprod[i][S_W+Q_W-1:FRAC_W]);
            // F1 = -(s * u_i): positive when the product is negative
            r_pos8[i] <= r_s7[S_W-1] != r_neg7[i];
        end
        r_zero8 <= r_zero7;
    end

    // stage 9: clip to the word range and register the result
    logic                   r_done, r_zero_o, r_sat_o;
    logic [2:0][WORD_W-1:0] r_f1, r_f2;
    logic [2:0][WORD_W-1:0] n_f1, n_f2;
    logic [2:0]             n_sat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sat[i] = 1'b0;
            if (r_zero8) begin
                n_f1[i] = '0;
                n_f2[i] = '0;
            end else if (r_pos8[i]) begin
                if (r_fm8[i] > POS_LIM) begin
                    n_f1[i]  = W_MAX;
                    n_sat[i] = 1'b1;
                end else begin
                    n_f1[i] = r_fm8[i][WORD_W-1:0];
                end
                n_f2[i] = -n_f1[i];
            end else begin
                // most negative first force cannot be negated: both sides clip
                if (r_fm8[i] >= NEG_LIM) begin
                    n_f1[i]  = W_MIN;
                    n_f2[i]  = W_MAX;
                    n_sat[i] = 1'b1;
                end else begin
                    n_f1[i] = -r_fm8[i][WORD_W-1:0];
                    n_f2[i] = r_fm8[i][WORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld8;
        end
        r_f1     <= n_f1;
        r_f2     <= n_f2;
        r_zero_o <= r_zero8;
        r_sat_o  <= |n_sat;
    end

    assign o_done           = r_done;
    assign o_first_force_x  = r_f1[0];
    assign o_first_force_y  = r_f1[1];
    assign o_first_force_z  = r_f1[2];
    assign o_second_force_x = r_f2[0];
    assign o_second_force_y = r_f2[1];
    assign o_second_force_z = r_f2[2];
    assign o_zero_length    = r_zero_o;
    assign o_saturated      = r_sat_o;

    // every transfer in comes out as a result on o_done
    `DSF_ASSERT(a_latency, start |-> ##DSF_LAT o_done)
    // coinciding particles give no force and no clipping
    `DSF_ASSERT(a_zero_len, o_done && o_zero_length |-> !o_saturated && o_first_force_x == 0 && o_second_force_z == 0)
    // without clipping the two forces are exact opposites
    `DSF_ASSERT(a_opposite, o_done && !o_saturated |-> o_second_force_y == -o_first_force_y)
    // no result right after reset
    `DSF_ASSERT_RST(a_reset, !i_rst_n |=> !o_done)

endmodule
